@@ design/cau_pkg.sv @@
// cau_pkg: operation codes and the control word that travels with each item
// through the complex arithmetic pipeline. No dependencies.
`default_nettype none

package cau_pkg;

  // Operation codes on in_operation
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Control word carried alongside the data from front stage C through every divider step
  typedef struct packed {
    logic       vld;     // stage holds an item
    logic [1:0] op;      // operation code
    logic       dz;      // divide with zero divisor
    logic       neg_re;  // real numerator is negative (divide only)
    logic       neg_im;  // imaginary numerator is negative (divide only)
  } cau_ctrl_t;

endpackage

`default_nettype wire

@@ design/cau_front.sv @@
// cau_front: three front stages: partial products, sums and divisor
// magnitude, then numerator magnitudes and rescaled pass values. Uses cau_pkg.
`default_nettype none

module cau_front import cau_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [1:0]                  in_op,
  input  logic signed [WORD_BITS-1:0] in_a_re,
  input  logic signed [WORD_BITS-1:0] in_a_im,
  input  logic signed [WORD_BITS-1:0] in_b_re,
  input  logic signed [WORD_BITS-1:0] in_b_im,
  output cau_ctrl_t                   ctrl_o,
  output logic [2*WORD_BITS-1:0]      den_o,
  output logic [2*WORD_BITS-1:0]      mag_re_o,
  output logic [2*WORD_BITS-1:0]      mag_im_o,
  output logic signed [2*WORD_BITS:0] pass_re_o,
  output logic signed [2*WORD_BITS:0] pass_im_o
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int SW = 2 * WORD_BITS + 1;

  // Stage A registers
  logic                 vld_a_r;
  logic [1:0]           op_a_r;
  logic signed [PW-1:0] p_rr_a_r, p_ii_a_r, p_ri_a_r, p_ir_a_r;
  logic signed [PW-1:0] sq_r_a_r, sq_i_a_r;
  logic signed [W:0]    as_re_a_r, as_im_a_r;
  logic signed [W:0]    as_re_nxt, as_im_nxt;

  // Stage B registers
  logic                 vld_b_r;
  logic [1:0]           op_b_r;
  logic signed [SW-1:0] sum_re_b_r, sum_im_b_r;
  logic [PW-1:0]        den_b_r;
  logic signed [SW-1:0] sum_re_nxt, sum_im_nxt;
  logic [PW-1:0]        den_nxt;

  // Stage C registers
  cau_ctrl_t            ctrl_c_r, ctrl_nxt;
  logic [PW-1:0]        den_c_r;
  logic [PW-1:0]        mag_re_c_r, mag_im_c_r;
  logic signed [SW-1:0] pass_re_c_r, pass_im_c_r;
  logic signed [SW-1:0] abs_re, abs_im;
  logic signed [SW-1:0] pass_re_nxt, pass_im_nxt;

  // Stage A: add or subtract per part, form the six products
  always_comb begin
    if (in_op == OP_SUB) begin
      as_re_nxt = (W+1)'(in_a_re) - (W+1)'(in_b_re);
      as_im_nxt = (W+1)'(in_a_im) - (W+1)'(in_b_im);
    end else begin
      as_re_nxt = (W+1)'(in_a_re) + (W+1)'(in_b_re);
      as_im_nxt = (W+1)'(in_a_im) + (W+1)'(in_b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r    <= in_op;
    as_re_a_r <= as_re_nxt;
    as_im_a_r <= as_im_nxt;
    p_rr_a_r  <= PW'(in_a_re) * PW'(in_b_re);
    p_ii_a_r  <= PW'(in_a_im) * PW'(in_b_im);
    p_ri_a_r  <= PW'(in_a_re) * PW'(in_b_im);
    p_ir_a_r  <= PW'(in_a_im) * PW'(in_b_re);
    sq_r_a_r  <= PW'(in_b_re) * PW'(in_b_re);
    sq_i_a_r  <= PW'(in_b_im) * PW'(in_b_im);
  end

  // Stage B: combine products per operation, sum the divisor squares
  always_comb begin
    case (op_a_r)
      OP_MUL: begin
        sum_re_nxt = SW'(p_rr_a_r) - SW'(p_ii_a_r);
        sum_im_nxt = SW'(p_ri_a_r) + SW'(p_ir_a_r);
      end
      OP_DIV: begin
        sum_re_nxt = SW'(p_rr_a_r) + SW'(p_ii_a_r);
        sum_im_nxt = SW'(p_ir_a_r) - SW'(p_ri_a_r);
      end
      default: begin
        sum_re_nxt = SW'(as_re_a_r);
        sum_im_nxt = SW'(as_im_a_r);
      end
    endcase
    // squares are nonnegative and their sum stays below 2^(PW-1)+1
    den_nxt = $unsigned(sq_r_a_r) + $unsigned(sq_i_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    op_b_r     <= op_a_r;
    sum_re_b_r <= sum_re_nxt;
    sum_im_b_r <= sum_im_nxt;
    den_b_r    <= den_nxt;
  end

  // Stage C: numerator magnitudes for the divider, rescale products
  always_comb begin
    abs_re = sum_re_b_r[SW-1] ? -sum_re_b_r : sum_re_b_r;
    abs_im = sum_im_b_r[SW-1] ? -sum_im_b_r : sum_im_b_r;

    if (op_b_r == OP_MUL) begin
      pass_re_nxt = sum_re_b_r >>> FRAC_BITS;
      pass_im_nxt = sum_im_b_r >>> FRAC_BITS;
    end else begin
      pass_re_nxt = sum_re_b_r;
      pass_im_nxt = sum_im_b_r;
    end

    ctrl_nxt.vld    = vld_b_r;
    ctrl_nxt.op     = op_b_r;
    ctrl_nxt.dz     = (op_b_r == OP_DIV) && (den_b_r == '0);
    ctrl_nxt.neg_re = sum_re_b_r[SW-1];
    ctrl_nxt.neg_im = sum_im_b_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_c_r <= '0;
    end else begin
      ctrl_c_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_c_r     <= den_b_r;
    mag_re_c_r  <= abs_re[PW-1:0];
    mag_im_c_r  <= abs_im[PW-1:0];
    pass_re_c_r <= pass_re_nxt;
    pass_im_c_r <= pass_im_nxt;
  end

  assign ctrl_o    = ctrl_c_r;
  assign den_o     = den_c_r;
  assign mag_re_o  = mag_re_c_r;
  assign mag_im_o  = mag_im_c_r;
  assign pass_re_o = pass_re_c_r;
  assign pass_im_o = pass_im_c_r;

endmodule

`default_nettype wire

@@ design/cau_div_step.sv @@
// cau_div_step: one registered restoring-division step for both numerator
// lanes; resolves one quotient bit and carries the rest of the item. Uses cau_pkg.
`default_nettype none

module cau_div_step import cau_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12,
  parameter int BIT_POS   = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cau_ctrl_t                             ctrl_i,
  input  logic [2*WORD_BITS-1:0]                den_i,
  input  logic [2*WORD_BITS-1:0]                mag_re_i,
  input  logic [2*WORD_BITS-1:0]                mag_im_i,
  input  logic signed [2*WORD_BITS:0]           pass_re_i,
  input  logic signed [2*WORD_BITS:0]           pass_im_i,
  input  logic [2*WORD_BITS-1:0]                rem_re_i,
  input  logic [2*WORD_BITS-1:0]                rem_im_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]      q_re_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]      q_im_i,
  output cau_ctrl_t                             ctrl_o,
  output logic [2*WORD_BITS-1:0]                den_o,
  output logic [2*WORD_BITS-1:0]                mag_re_o,
  output logic [2*WORD_BITS-1:0]                mag_im_o,
  output logic signed [2*WORD_BITS:0]           pass_re_o,
  output logic signed [2*WORD_BITS:0]           pass_im_o,
  output logic [2*WORD_BITS-1:0]                rem_re_o,
  output logic [2*WORD_BITS-1:0]                rem_im_o,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]      q_re_o,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]      q_im_o
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = 2 * WORD_BITS + 1;
  localparam int NB = 2 * WORD_BITS + FRAC_BITS;

  logic            nbit_re, nbit_im;
  logic [SW-1:0]   trial_re, trial_im;
  logic [SW-1:0]   diff_re, diff_im;
  logic            ge_re, ge_im;
  logic [PW-1:0]   rem_re_nxt, rem_im_nxt;

  cau_ctrl_t            ctrl_r;
  logic [PW-1:0]        den_r, mag_re_r, mag_im_r, rem_re_r, rem_im_r;
  logic signed [SW-1:0] pass_re_r, pass_im_r;
  logic [NB-1:0]        q_re_r, q_im_r;

  // Pick this step's bit of the numerator shifted up by the fraction bits
  generate
    if (BIT_POS >= FRAC_BITS) begin : g_num_bit
      assign nbit_re = mag_re_i[BIT_POS-FRAC_BITS];
      assign nbit_im = mag_im_i[BIT_POS-FRAC_BITS];
    end else begin : g_zero_bit
      assign nbit_re = 1'b0;
      assign nbit_im = 1'b0;
    end
  endgenerate

  // Shift in the numerator bit, subtract the divisor where it fits
  always_comb begin
    trial_re   = {rem_re_i, nbit_re};
    trial_im   = {rem_im_i, nbit_im};
    diff_re    = trial_re - {1'b0, den_i};
    diff_im    = trial_im - {1'b0, den_i};
    ge_re      = trial_re >= {1'b0, den_i};
    ge_im      = trial_im >= {1'b0, den_i};
    rem_re_nxt = ge_re ? diff_re[PW-1:0] : trial_re[PW-1:0];
    rem_im_nxt = ge_im ? diff_im[PW-1:0] : trial_im[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    den_r     <= den_i;
    mag_re_r  <= mag_re_i;
    mag_im_r  <= mag_im_i;
    pass_re_r <= pass_re_i;
    pass_im_r <= pass_im_i;
    rem_re_r  <= rem_re_nxt;
    rem_im_r  <= rem_im_nxt;
    q_re_r    <= {q_re_i[NB-2:0], ge_re};
    q_im_r    <= {q_im_i[NB-2:0], ge_im};
  end

  assign ctrl_o    = ctrl_r;
  assign den_o     = den_r;
  assign mag_re_o  = mag_re_r;
  assign mag_im_o  = mag_im_r;
  assign pass_re_o = pass_re_r;
  assign pass_im_o = pass_im_r;
  assign rem_re_o  = rem_re_r;
  assign rem_im_o  = rem_im_r;
  assign q_re_o    = q_re_r;
  assign q_im_o    = q_im_r;

endmodule

`default_nettype wire

@@ design/cau_back.sv @@
// cau_back: output stage; applies the quotient signs, saturates both parts
// to the word range (zero on a divide by zero) and registers the result strobe. Uses cau_pkg.
`default_nettype none

module cau_back import cau_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cau_ctrl_t                        ctrl_i,
  input  logic signed [2*WORD_BITS:0]      pass_re_i,
  input  logic signed [2*WORD_BITS:0]      pass_im_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0] q_re_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0] q_im_i,
  output logic                             out_valid,
  output logic signed [WORD_BITS-1:0]      out_res_re,
  output logic signed [WORD_BITS-1:0]      out_res_im,
  output logic                             out_overflow,
  output logic                             out_div_by_zero
);

  localparam int W  = WORD_BITS;
  localparam int VB = 2 * WORD_BITS + FRAC_BITS + 1;

  logic signed [VB-1:0] val_re, val_im;
  logic                 ovf_re, ovf_im;
  logic [W-1:0]         sat_re, sat_im;
  logic [W-1:0]         res_re_nxt, res_im_nxt;
  logic                 ovf_nxt;

  logic                 valid_r;
  logic [W-1:0]         res_re_r, res_im_r;
  logic                 ovf_r, dz_r;

  // Select the exact value of each part and saturate it
  always_comb begin
    if (ctrl_i.op == OP_DIV) begin
      val_re = ctrl_i.neg_re ? -VB'(q_re_i) : VB'(q_re_i);
      val_im = ctrl_i.neg_im ? -VB'(q_im_i) : VB'(q_im_i);
    end else begin
      val_re = VB'(pass_re_i);
      val_im = VB'(pass_im_i);
    end

    // out of range unless the bits from the word's sign bit up all agree
    ovf_re = !((&val_re[VB-1:W-1]) || (~|val_re[VB-1:W-1]));
    ovf_im = !((&val_im[VB-1:W-1]) || (~|val_im[VB-1:W-1]));
    sat_re = val_re[VB-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat_im = val_im[VB-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    if (ctrl_i.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      ovf_nxt    = 1'b0;
    end else begin
      res_re_nxt = ovf_re ? sat_re : val_re[W-1:0];
      res_im_nxt = ovf_im ? sat_im : val_im[W-1:0];
      ovf_nxt    = ovf_re || ovf_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    ovf_r    <= ovf_nxt;
    dz_r     <= ctrl_i.dz;
  end

  assign out_valid       = valid_r;
  assign out_res_re      = res_re_r;
  assign out_res_im      = res_im_r;
  assign out_overflow    = ovf_r;
  assign out_div_by_zero = dz_r;

endmodule

`default_nettype wire

@@ design/complex_arith_unit.sv @@
// complex_arith_unit: top level of the pipelined complex add, subtract,
// multiply and divide unit. Uses cau_pkg, cau_front, cau_div_step, cau_back.
//
// Usage
//   Input: drive in_operation and the four operand parts with start high;
//   the operation is taken at a rising edge where start is high and busy is
//   low. busy is low whenever rst_n is high, so one operation can be
//   started in every cycle.
//   Result: out_valid is high for exactly one cycle with out_res_re,
//   out_res_im, out_overflow and out_div_by_zero; the receiver must take it
//   then, since there is no back-pressure.
//   Order: every operation passes through every stage, so results leave
//   in the order the operations went in. Throughput: one transfer per
//   cycle while rst_n is high. The divider has one restoring step per
//   quotient bit, 2*WORD_BITS + FRAC_BITS steps, each in its own register
//   stage, after three front stages (products, sums, magnitudes) and one
//   output stage.
//   Reset: synchronous; clears every stage's valid bit, so operations in
//   flight are dropped and no result appears until new ones are started.
//   busy is high while rst_n is low.
`default_nettype none

module complex_arith_unit import cau_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic signed [WORD_BITS-1:0] in_a_re,
  input  logic signed [WORD_BITS-1:0] in_a_im,
  input  logic signed [WORD_BITS-1:0] in_b_re,
  input  logic signed [WORD_BITS-1:0] in_b_im,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_res_re,
  output logic signed [WORD_BITS-1:0] out_res_im,
  output logic                        out_overflow,
  output logic                        out_div_by_zero
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = 2 * WORD_BITS + 1;
  localparam int NB = 2 * WORD_BITS + FRAC_BITS;

  logic in_xfer;

  // Divider chain taps: index 0 feeds the first step, NB leaves the last
  cau_ctrl_t            ctrl_s    [0:NB];
  logic [PW-1:0]        den_s     [0:NB];
  logic [PW-1:0]        mag_re_s  [0:NB];
  logic [PW-1:0]        mag_im_s  [0:NB];
  logic signed [SW-1:0] pass_re_s [0:NB];
  logic signed [SW-1:0] pass_im_s [0:NB];
  logic [PW-1:0]        rem_re_s  [0:NB];
  logic [PW-1:0]        rem_im_s  [0:NB];
  logic [NB-1:0]        q_re_s    [0:NB];
  logic [NB-1:0]        q_im_s    [0:NB];

  // Hold off transfers only while in reset
  assign busy    = ~rst_n;
  assign in_xfer = start && !busy;

  cau_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_xfer),
    .in_op     (in_operation),
    .in_a_re   (in_a_re),
    .in_a_im   (in_a_im),
    .in_b_re   (in_b_re),
    .in_b_im   (in_b_im),
    .ctrl_o    (ctrl_s[0]),
    .den_o     (den_s[0]),
    .mag_re_o  (mag_re_s[0]),
    .mag_im_o  (mag_im_s[0]),
    .pass_re_o (pass_re_s[0]),
    .pass_im_o (pass_im_s[0])
  );

  // Start each division with an empty remainder and quotient
  assign rem_re_s[0] = '0;
  assign rem_im_s[0] = '0;
  assign q_re_s[0]   = '0;
  assign q_im_s[0]   = '0;

  // One step per quotient bit, most significant first
  generate
    for (genvar g = 0; g < NB; g++) begin : g_div
      cau_div_step #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .BIT_POS   (NB - 1 - g)
      ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_i    (ctrl_s[g]),
        .den_i     (den_s[g]),
        .mag_re_i  (mag_re_s[g]),
        .mag_im_i  (mag_im_s[g]),
        .pass_re_i (pass_re_s[g]),
        .pass_im_i (pass_im_s[g]),
        .rem_re_i  (rem_re_s[g]),
        .rem_im_i  (rem_im_s[g]),
        .q_re_i    (q_re_s[g]),
        .q_im_i    (q_im_s[g]),
        .ctrl_o    (ctrl_s[g+1]),
        .den_o     (den_s[g+1]),
        .mag_re_o  (mag_re_s[g+1]),
        .mag_im_o  (mag_im_s[g+1]),
        .pass_re_o (pass_re_s[g+1]),
        .pass_im_o (pass_im_s[g+1]),
        .rem_re_o  (rem_re_s[g+1]),
        .rem_im_o  (rem_im_s[g+1]),
        .q_re_o    (q_re_s[g+1]),
        .q_im_o    (q_im_s[g+1])
      );
    end
  endgenerate

  cau_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl_i          (ctrl_s[NB]),
    .pass_re_i       (pass_re_s[NB]),
    .pass_im_i       (pass_im_s[NB]),
    .q_re_i          (q_re_s[NB]),
    .q_im_i          (q_im_s[NB]),
    .out_valid       (out_valid),
    .out_res_re      (out_res_re),
    .out_res_im      (out_res_im),
    .out_overflow    (out_overflow),
    .out_div_by_zero (out_div_by_zero)
  );

endmodule

`default_nettype wire

@@ design/cau_checker.sv @@
// cau_checker: port-level checks of the complex arithmetic unit, bound to
// every instance of complex_arith_unit. Uses cau_pkg.
`default_nettype none

module cau_checker import cau_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           in_operation,
  input logic [WORD_BITS-1:0] in_b_re,
  input logic [WORD_BITS-1:0] in_b_im,
  input logic                 out_valid,
  input logic [WORD_BITS-1:0] out_res_re,
  input logic [WORD_BITS-1:0] out_res_im,
  input logic                 out_overflow,
  input logic                 out_div_by_zero
);

  localparam int LAT = 2 * WORD_BITS + FRAC_BITS + 4;
  localparam logic [WORD_BITS-1:0] MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Every transfer in yields a result at the delay set by LAT
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("transfer in without result after the pipeline latency");

  // No result without a matching transfer in
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transfer in");

  // Divide-by-zero only for a divide whose divisor was zero
  a_dz_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |->
      $past(in_operation == OP_DIV && in_b_re == '0 && in_b_im == '0, LAT))
    else $error("divide-by-zero flag without a zero divisor");

  // Divide-by-zero gives a zero result and no overflow
  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |->
      (out_res_re == '0 && out_res_im == '0 && !out_overflow))
    else $error("divide-by-zero result not cleared");

  // Overflow means at least one part sits at a range limit
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_res_re == MAX_W || out_res_re == MIN_W ||
       out_res_im == MAX_W || out_res_im == MIN_W))
    else $error("overflow flagged without a saturated part");

endmodule

bind complex_arith_unit cau_checker #(
  .WORD_BITS (WORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_cau_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for complex_arith_unit (add, sub, mul, div).
// Depends on cau_pkg for operation codes and on the RTL of complex_arith_unit.
`timescale 1ns / 1ps

module testbench import cau_pkg::*;;

  localparam int WORD_BITS    = 16;
  localparam int FRAC_BITS    = 12;
  localparam int LATENCY      = 2 * WORD_BITS + FRAC_BITS + 4;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = word_t'((1 << (WORD_BITS - 1)) - 1);
  localparam word_t WORD_MIN = word_t'(1 << (WORD_BITS - 1));
  localparam word_t ONE_FX   = word_t'(1 << FRAC_BITS);

  typedef struct {
    logic [1:0] op;
    word_t      a_re;
    word_t      a_im;
    word_t      b_re;
    word_t      b_im;
  } cplx_op_t;

  typedef struct {
    word_t re;
    word_t im;
    logic  ovf;
    logic  dz;
  } cplx_res_t;

  // Scoreboard: predict each accepted operation and match results in order
  class cplx_scoreboard;
    cplx_res_t pending_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Clamp an exact value to the word range, flag when clamped
    function word_t clamp_word(longint v, inout logic ovf);
      longint top;
      longint bottom;
      top    = (longint'(1) <<< (WORD_BITS - 1)) - 1;
      bottom = -top - 1;
      if (v > top) begin
        ovf = 1'b1;
        return word_t'(top);
      end
      if (v < bottom) begin
        ovf = 1'b1;
        return word_t'(bottom);
      end
      return word_t'(v);
    endfunction

    function cplx_res_t compute_result(cplx_op_t x);
      longint    ar, ai, br, bi;
      longint    ex_re, ex_im, den;
      cplx_res_t r;
      ar    = longint'(x.a_re);
      ai    = longint'(x.a_im);
      br    = longint'(x.b_re);
      bi    = longint'(x.b_im);
      ex_re = 0;
      ex_im = 0;
      r.ovf = 1'b0;
      r.dz  = 1'b0;
      case (x.op)
        OP_ADD: begin
          ex_re = ar + br;
          ex_im = ai + bi;
        end
        OP_SUB: begin
          ex_re = ar - br;
          ex_im = ai - bi;
        end
        OP_MUL: begin
          // full products, then arithmetic shift (rounds toward minus infinity)
          ex_re = (ar * br - ai * bi) >>> FRAC_BITS;
          ex_im = (ar * bi + ai * br) >>> FRAC_BITS;
        end
        OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.dz = 1'b1;
          end else begin
            // signed division truncates toward zero
            ex_re = ((ar * br + ai * bi) <<< FRAC_BITS) / den;
            ex_im = ((br * ai - bi * ar) <<< FRAC_BITS) / den;
          end
        end
        default: ;
      endcase
      r.re = clamp_word(ex_re, r.ovf);
      r.im = clamp_word(ex_im, r.ovf);
      return r;
    endfunction

    function void note_item(cplx_op_t x);
      pending_q.push_back(compute_result(x));
    endfunction

    function void check_result(cplx_res_t got);
      cplx_res_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result re %0d im %0d ovf %b dz %b", $time,
                 got.re, got.im, got.ovf, got.dz);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.re !== exp_r.re) begin
        $display("%0t: res_re mismatch: expected %0d, actual %0d", $time, exp_r.re, got.re);
        errors++;
      end
      if (got.im !== exp_r.im) begin
        $display("%0t: res_im mismatch: expected %0d, actual %0d", $time, exp_r.im, got.im);
        errors++;
      end
      if (got.ovf !== exp_r.ovf) begin
        $display("%0t: overflow mismatch: expected %b, actual %b", $time, exp_r.ovf, got.ovf);
        errors++;
      end
      if (got.dz !== exp_r.dz) begin
        $display("%0t: div_by_zero mismatch: expected %b, actual %b", $time, exp_r.dz,
                 got.dz);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_operation;
  word_t      in_a_re, in_a_im, in_b_re, in_b_im;
  logic       out_valid;
  word_t      out_res_re, out_res_im;
  logic       out_overflow, out_div_by_zero;

  cplx_scoreboard sb;
  int             cycle_count;
  bit             burst_mode;

  complex_arith_unit #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_a_re        (in_a_re),
    .in_a_im        (in_a_im),
    .in_b_re        (in_b_re),
    .in_b_im        (in_b_im),
    .out_valid      (out_valid),
    .out_res_re     (out_res_re),
    .out_res_im     (out_res_im),
    .out_overflow   (out_overflow),
    .out_div_by_zero(out_div_by_zero)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bound the run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Record each input transfer and check each result at the rising edge
  always @(posedge clk) begin
    cplx_op_t  seen_op;
    cplx_res_t seen_res;
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) begin
        seen_op.op   = in_operation;
        seen_op.a_re = in_a_re;
        seen_op.a_im = in_a_im;
        seen_op.b_re = in_b_re;
        seen_op.b_im = in_b_im;
        sb.note_item(seen_op);
      end
      if (out_valid === 1'b1) begin
        seen_res.re  = out_res_re;
        seen_res.im  = out_res_im;
        seen_res.ovf = out_overflow;
        seen_res.dz  = out_div_by_zero;
        sb.check_result(seen_res);
      end else if (out_valid !== 1'b0) begin
        $display("%0t: out_valid mismatch: expected 0 or 1, actual %b", $time, out_valid);
        sb.errors++;
      end
    end
  end

  // Offer one operation, hold it until the transfer, then idle for a random gap (none in burst mode)
  task automatic send_op(input logic [1:0] op, input word_t ar, input word_t ai,
                         input word_t br, input word_t bi);
    int gap;
    in_operation = op;
    in_a_re      = ar;
    in_a_im      = ai;
    in_b_re      = br;
    in_b_im      = bi;
    start        = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        // scramble the idle bus: the block must ignore it
        in_operation = 2'($urandom);
        in_a_re      = word_t'($urandom);
        in_a_im      = word_t'($urandom);
        in_b_re      = word_t'($urandom);
        in_b_im      = word_t'($urandom);
        @(negedge clk);
      end
    end
  endtask

  // Hold off new operations until every expected result has come back
  task automatic drain_results();
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Operand mix: extremes, zero and plus or minus one, unity-scale values and full-range noise
  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return word_t'(1);
      4:       return word_t'(-1);
      5, 6:    return word_t'(int'($urandom_range(0, 2 * ONE_FX)) - ONE_FX);
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    word_t      br, bi;
    sb           = new();
    cycle_count  = 0;
    burst_mode   = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_ADD;
    in_a_re      = '0;
    in_a_im      = '0;
    in_b_re      = '0;
    in_b_im      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: saturation at both ends, rounding, truncation, zero divisor
    send_op(OP_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    send_op(OP_ADD, WORD_MAX, word_t'(-1), word_t'(0), word_t'(1));
    send_op(OP_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    send_op(OP_SUB, '0, '0, WORD_MIN, WORD_MAX);
    send_op(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_op(OP_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN);
    send_op(OP_MUL, word_t'(-1), '0, word_t'(1), '0);
    send_op(OP_MUL, ONE_FX, '0, word_t'(12345), word_t'(-777));
    send_op(OP_MUL, word_t'(5000), word_t'(-3), '0, '0);
    send_op(OP_DIV, ONE_FX, '0, ONE_FX, '0);
    send_op(OP_DIV, '0, ONE_FX, '0, ONE_FX);
    send_op(OP_DIV, word_t'(-1), '0, WORD_MAX, '0);
    send_op(OP_DIV, word_t'(1), word_t'(-1), '0, WORD_MAX);
    send_op(OP_DIV, WORD_MAX, '0, word_t'(1), '0);
    send_op(OP_DIV, WORD_MIN, WORD_MIN, '0, word_t'(-1));
    send_op(OP_DIV, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN);
    send_op(OP_DIV, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX);
    send_op(OP_DIV, WORD_MAX, WORD_MIN, '0, '0);
    send_op(OP_DIV, '0, '0, '0, '0);
    send_op(OP_MUL, WORD_MAX, WORD_MAX, '0, '0);
    send_op(OP_SUB, word_t'(16'h5555), word_t'(16'hAAAA), word_t'(16'hAAAA),
            word_t'(16'h5555));
    drain_results();

    // Random: mixed operations, bursts with no gaps, one drain midway
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain_results();
      op = 2'($urandom_range(0, 3));
      br = pick_word();
      bi = pick_word();
      if (op == OP_DIV && $urandom_range(0, 19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_op(op, pick_word(), pick_word(), br, bi);
    end

    // Wait out every result, then allow for stray late results
    drain_results();
    repeat (LATENCY + 8) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
